@@ hw/rtl/jerk_triple_integrator_defines.svh @@
// Assertion macros shared by the jerk triple integrator RTL.
`ifndef JERK_TRIPLE_INTEGRATOR_DEFINES_SVH
`define JERK_TRIPLE_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JTI_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("jti assertion failed");

// Next-cycle implication, disabled during reset.
`define JTI_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("jti assertion failed");

`endif

@@ hw/rtl/jti_pkg.sv @@
// Package with types, constants and limit tables of the jerk triple integrator.
package jti_pkg;

    localparam int NUM_JOINTS_DEF = 7;
    localparam int JIDX_W = 5;
    localparam logic [19:0] US_PER_S = 20'd1000000;
    localparam logic [21:0] US_PER_2S = 22'd2000000;
    // floor(2^51 / 1e6): dt estimate is elapsed * DT_RECIP / 2^19.
    localparam logic [31:0] DT_RECIP = 32'd2251799813;
    localparam logic [31:0] RECIP6 = 32'hAAAAAAAB;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_DT_MAX = 2'd1;
    localparam logic [1:0] CFG_DT_MIN = 2'd2;
    localparam logic [1:0] CFG_DEFAULT_DT = 2'd3;

    localparam logic OP_SOLUTION = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  joint_index;
        logic [31:0] time_us;
        logic signed [31:0] start_position;
        logic signed [31:0] start_velocity;
        logic signed [31:0] start_acceleration;
        logic signed [31:0] jerk_value;
        logic        jerk_valid;
        logic        last_joint;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_joint;
        logic signed [31:0] cmd_position;
        logic signed [31:0] cmd_velocity;
        logic signed [31:0] cmd_acceleration;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [3:0] {
        MS_QEST, MS_QBACK, MS_D2, MS_D3, MS_SD3, MS_VDT, MS_AHD2, MS_KSD3, MS_ADT,
        MS_KHD2, MS_KDT
    } mul_sel_t;

    typedef struct packed {
        logic        apply_sol;
        logic        kill;
        logic        start_tick;
        logic        div_fix;
        logic        mul_go;
        mul_sel_t    mul_sel;
        logic        joint_init;
        logic        finish;
        logic [JIDX_W-1:0] joint;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic live;
        logic expired;
        logic out_free;
    } status_t;

    // Limit row for a joint; joints past the table use its last row.
    function automatic logic [2:0] rom_row(input logic [JIDX_W-1:0] joint);
        logic [2:0] r;
        r = (joint < JIDX_W'(7)) ? joint[2:0] : 3'd6;
        return r;
    endfunction

    function automatic logic signed [31:0] pos_lo(input logic [JIDX_W-1:0] joint);
        logic signed [31:0] v;
        case (rom_row(joint))
            3'd1: v = -32'sd1848430;
            3'd3: v = -32'sd3221016;
            3'd5: v = -32'sd18350;
            default: v = -32'sd3038039;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] pos_hi(input logic [JIDX_W-1:0] joint);
        logic signed [31:0] v;
        case (rom_row(joint))
            3'd1: v = 32'sd1848430;
            3'd3: v = -32'sd73191;
            3'd5: v = 32'sd3934781;
            default: v = 32'sd3038039;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] vel_lim(input logic [JIDX_W-1:0] joint);
        logic signed [31:0] v;
        case (rom_row(joint))
            3'd0, 3'd1, 3'd2, 3'd3: v = 32'sd2280653;
            default: v = 32'sd2736783;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] acc_lim(input logic [JIDX_W-1:0] joint);
        logic signed [31:0] v;
        case (rom_row(joint))
            3'd1: v = 32'sd7864320;
            3'd2: v = 32'sd10485760;
            3'd3: v = 32'sd13107200;
            3'd5, 3'd6: v = 32'sd20971520;
            default: v = 32'sd15728640;
        endcase
        return v;
    endfunction

    // Saturate a wide sum into the given range.
    function automatic logic signed [31:0] clamp36(input logic signed [35:0] v,
                                                    input logic signed [31:0] lo,
                                                    input logic signed [31:0] hi);
        logic signed [31:0] r;
        if (v < 36'(lo))
            r = lo;
        else if (v > 36'(hi))
            r = hi;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/jti_ctrl.sv @@
// Sequencer of the jerk triple integrator: decode, dt division, joint loop.
module jti_ctrl
    import jti_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_accept,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_DIV, S_PRE, S_JOINT, S_FIN} state_t;

    state_t            state_reg, state_next;
    logic [4:0]        step_reg, step_next;
    logic [JIDX_W-1:0] joint_reg, joint_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        joint_next = joint_reg;
        cmd        = '0;
        cmd.mul_sel = MS_D2;
        cmd.joint  = joint_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (!status.is_tick)
                    cmd.apply_sol = 1'b1;
                else if (status.live && status.expired)
                    cmd.kill = 1'b1;
                else if (status.live)
                begin
                    cmd.start_tick = 1'b1;
                    step_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Reciprocal estimate, back-multiply, then one correction step.
                cmd.mul_go  = (step_reg == 5'd0) || (step_reg == 5'd2);
                cmd.div_fix = (step_reg == 5'd4);
                case (step_reg)
                    5'd2: cmd.mul_sel = MS_QBACK;
                    default: cmd.mul_sel = MS_QEST;
                endcase
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd4)
                begin
                    step_next = '0;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                // Even steps issue a product, odd steps let it land.
                cmd.mul_go = !step_reg[0];
                case (step_reg)
                    5'd2: cmd.mul_sel = MS_D3;
                    5'd4: cmd.mul_sel = MS_SD3;
                    default: cmd.mul_sel = MS_D2;
                endcase
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd5)
                begin
                    step_next = '0;
                    joint_next = '0;
                    state_next = S_JOINT;
                end
            end
            S_JOINT:
            begin
                cmd.joint_init = (step_reg == 5'd0);
                cmd.mul_go = (step_reg <= 5'd5);
                case (step_reg)
                    5'd1: cmd.mul_sel = MS_AHD2;
                    5'd2: cmd.mul_sel = MS_KSD3;
                    5'd3: cmd.mul_sel = MS_ADT;
                    5'd4: cmd.mul_sel = MS_KHD2;
                    5'd5: cmd.mul_sel = MS_KDT;
                    default: cmd.mul_sel = MS_VDT;
                endcase
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd6)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    step_next = '0;
                    if (joint_reg == JIDX_W'(NUM_JOINTS - 1))
                        state_next = S_IDLE;
                    else
                    begin
                        joint_next = joint_reg + JIDX_W'(1);
                        state_next = S_JOINT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            joint_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            joint_reg <= joint_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ hw/rtl/jti_datapath.sv @@
// Datapath of the jerk triple integrator: joint state, dt divider, multiplier, output register.
module jti_datapath
    import jti_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_accept,
    input  in_item_t  in_data,
    input  logic      cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [19:0] cfg_data,
    input  cmd_t      cmd,
    output status_t   status,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    logic signed [31:0] pos_reg [NUM_JOINTS];
    logic signed [31:0] vel_reg [NUM_JOINTS];
    logic signed [31:0] accl_reg [NUM_JOINTS];
    logic signed [31:0] jerk_reg [NUM_JOINTS];

    in_item_t    item_reg;
    logic        live_reg, first_load_reg;
    logic [31:0] last_sol_reg, last_tick_reg;
    logic [19:0] timeout_reg, dt_max_reg, dt_min_reg, default_dt_reg;

    logic [19:0] el_reg;
    logic [21:0] rem_reg;
    logic [31:0] quot_reg;
    logic        sat_reg;
    logic [31:0] d2_reg, d3_reg, sd3_reg;

    logic signed [65:0] prod_reg;
    mul_sel_t    sel_reg;
    logic        prod_vld_reg;
    logic signed [35:0] acc_p_reg, acc_v_reg, acc_a_reg;

    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [31:0] dt, hd2, age, elapsed;
    logic [19:0] el_sel;
    logic [JIDX_W-1:0] sol_joint;
    logic [JW-1:0] sol_idx, cur_idx;
    logic        sol_in_range;
    logic signed [31:0] cur_p, cur_v, cur_a, cur_k;
    logic signed [32:0] mul_a, mul_b;
    logic signed [35:0] term;
    logic signed [31:0] new_p, new_v, new_a;

    // Watchdog and elapsed time of a tick.
    always_comb
    begin
        age = item_reg.time_us - last_sol_reg;
        elapsed = item_reg.time_us - last_tick_reg;
        el_sel = (elapsed > 32'(dt_max_reg)) ? dt_max_reg : elapsed[19:0];
        if (el_sel < dt_min_reg)
            el_sel = default_dt_reg;
    end

    assign status.is_tick  = (item_reg.opcode == OP_TICK);
    assign status.live     = live_reg;
    assign status.expired  = (age > 32'(timeout_reg));
    assign status.out_free = !out_valid_reg || !out_stall;

    // The quotient of elapsed * 2^32 / 1e6 saturates from one second upward.
    assign dt        = sat_reg ? 32'hFFFFFFFF : quot_reg;
    assign hd2       = {1'b0, d2_reg[31:1]};

    // Joint addressing.
    assign sol_joint    = JIDX_W'(item_reg.joint_index);
    assign sol_in_range = (sol_joint < JIDX_W'(NUM_JOINTS));
    assign sol_idx      = sol_joint[JW-1:0];
    assign cur_idx      = cmd.joint[JW-1:0];
    assign cur_p = pos_reg[cur_idx];
    assign cur_v = vel_reg[cur_idx];
    assign cur_a = accl_reg[cur_idx];
    assign cur_k = jerk_reg[cur_idx];

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd.mul_sel)
            MS_QEST: begin mul_a = {13'd0, el_reg};   mul_b = {1'b0, DT_RECIP}; end
            MS_QBACK: begin mul_a = {1'b0, quot_reg}; mul_b = {13'd0, US_PER_S}; end
            MS_D2:   begin mul_a = {1'b0, dt};     mul_b = {1'b0, dt};     end
            MS_D3:   begin mul_a = {1'b0, d2_reg}; mul_b = {1'b0, dt};     end
            MS_SD3:  begin mul_a = {1'b0, d3_reg}; mul_b = {1'b0, RECIP6}; end
            MS_VDT:  begin mul_a = {cur_v[31], cur_v}; mul_b = {1'b0, dt};      end
            MS_AHD2: begin mul_a = {cur_a[31], cur_a}; mul_b = {1'b0, hd2};     end
            MS_KSD3: begin mul_a = {cur_k[31], cur_k}; mul_b = {1'b0, sd3_reg}; end
            MS_ADT:  begin mul_a = {cur_a[31], cur_a}; mul_b = {1'b0, dt};      end
            MS_KHD2: begin mul_a = {cur_k[31], cur_k}; mul_b = {1'b0, hd2};     end
            MS_KDT:  begin mul_a = {cur_k[31], cur_k}; mul_b = {1'b0, dt};      end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Floor of product / 2^32 always fits in 32 signed bits.
    assign term = 36'(signed'(prod_reg[63:32]));

    // Clamp the finished sums to the joint's limits.
    assign new_p = clamp36(acc_p_reg, pos_lo(cmd.joint), pos_hi(cmd.joint));
    assign new_v = clamp36(acc_v_reg, -vel_lim(cmd.joint), vel_lim(cmd.joint));
    assign new_a = clamp36(acc_a_reg, -acc_lim(cmd.joint), acc_lim(cmd.joint));

    // Control state, configuration and joint state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                accl_reg[i] <= '0;
                jerk_reg[i] <= '0;
            end
            live_reg       <= 1'b0;
            first_load_reg <= 1'b1;
            last_sol_reg   <= '0;
            last_tick_reg  <= '0;
            timeout_reg    <= 20'd70000;
            dt_max_reg     <= 20'd10000;
            dt_min_reg     <= 20'd100;
            default_dt_reg <= 20'd1000;
            prod_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                    CFG_DT_MAX:     dt_max_reg     <= cfg_data;
                    CFG_DT_MIN:     dt_min_reg     <= cfg_data;
                    CFG_DEFAULT_DT: default_dt_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Solution transaction for one joint.
            if (cmd.apply_sol)
            begin
                if (sol_in_range)
                begin
                    if (first_load_reg)
                    begin
                        pos_reg[sol_idx]  <= item_reg.start_position;
                        vel_reg[sol_idx]  <= item_reg.start_velocity;
                        accl_reg[sol_idx] <= item_reg.start_acceleration;
                    end
                    if (item_reg.jerk_valid)
                        jerk_reg[sol_idx] <= item_reg.jerk_value;
                end
                last_sol_reg <= item_reg.time_us;
                live_reg <= 1'b1;
                if (item_reg.last_joint)
                    first_load_reg <= 1'b0;
            end

            if (cmd.kill)
                live_reg <= 1'b0;
            if (cmd.start_tick)
                last_tick_reg <= item_reg.time_us;

            prod_vld_reg <= cmd.mul_go;

            // Write back the clamped joint.
            if (cmd.finish)
            begin
                pos_reg[cur_idx]  <= new_p;
                vel_reg[cur_idx]  <= new_v;
                accl_reg[cur_idx] <= new_a;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            item_reg <= in_data;

        if (cmd.start_tick)
        begin
            el_reg  <= el_sel;
            sat_reg <= (el_sel >= US_PER_S);
        end

        if (cmd.mul_go)
        begin
            prod_reg <= mul_a * mul_b;
            sel_reg  <= cmd.mul_sel;
        end

        // The estimate is at most two below the quotient; the remainder fixes it.
        if (cmd.joint_init)
        begin
            acc_p_reg <= 36'(cur_p);
            acc_v_reg <= 36'(cur_v);
            acc_a_reg <= 36'(cur_a);
        end
        else if (cmd.div_fix)
        begin
            if (rem_reg >= US_PER_2S)
                quot_reg <= quot_reg + 32'd2;
            else if (rem_reg >= 22'(US_PER_S))
                quot_reg <= quot_reg + 32'd1;
        end
        else if (prod_vld_reg)
        begin
            case (sel_reg)
                MS_QEST:  quot_reg <= prod_reg[50:19];
                MS_QBACK: rem_reg  <= 22'd0 - prod_reg[21:0];
                MS_D2:  d2_reg  <= prod_reg[63:32];
                MS_D3:  d3_reg  <= prod_reg[63:32];
                MS_SD3: sd3_reg <= prod_reg[65:34];
                MS_VDT, MS_AHD2, MS_KSD3: acc_p_reg <= acc_p_reg + term;
                MS_ADT, MS_KHD2:          acc_v_reg <= acc_v_reg + term;
                MS_KDT:                   acc_a_reg <= acc_a_reg + term;
                default: ;
            endcase
        end

        if (cmd.finish)
        begin
            out_reg.out_joint        <= cmd.joint[2:0];
            out_reg.cmd_position     <= new_p;
            out_reg.cmd_velocity     <= new_v;
            out_reg.cmd_acceleration <= new_a;
            out_reg.last_of_run      <= (cmd.joint == JIDX_W'(NUM_JOINTS - 1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hw/rtl/jerk_triple_integrator.sv @@
// Top level of the jerk-driven triple integrator with solution watchdog.
//
// Input channel (in_valid/in_stall/in_data) takes solution transactions, one
// per joint, and tick transactions carrying a microsecond timestamp. in_stall
// is high whenever the sequencer is busy; one transaction is handled at a time.
// A solution transaction produces no result. A tick that integrates goes
// through accept and decode, a division phase that turns the elapsed time
// into dt by a reciprocal multiply, a back-multiply and one correction, a
// phase for dt^2, dt^3 and dt^3/6 on the shared multiplier, then a pass per
// joint for six products, clamp and write-back.
// Each joint's result goes to the output register (out_valid/out_stall/out_data);
// while the receiver stalls, the sequencer holds at the next write-back.
// A tick without a live solution or with an expired watchdog produces nothing.
// The configuration channel (cfg_valid/cfg_ready) is always ready and should
// be written only while the block is idle.
// Reset clears all joint state, arms the first-load flag and loads the
// default timing registers.
module jerk_triple_integrator
    import jti_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [19:0] cfg_data
);

`include "jerk_triple_integrator_defines.svh"

    logic    in_accept, busy;
    cmd_t    cmd;
    status_t status;

    assign in_stall  = busy;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Sequencer.
    jti_ctrl #(.NUM_JOINTS(NUM_JOINTS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Arithmetic and state.
    jti_datapath #(.NUM_JOINTS(NUM_JOINTS)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A transaction always keeps the block busy in the following cycle.
    `JTI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall)
    // A pending result that is not the last of its run means the run goes on.
    `JTI_ASSERT_NOW(a_mid_run_busy, clk, rst_n, out_valid && !out_data.last_of_run, in_stall)
    // The last result of a run belongs to the highest joint.
    `JTI_ASSERT_NOW(a_last_joint, clk, rst_n, out_valid && out_data.last_of_run,
        out_data.out_joint == 3'(NUM_JOINTS - 1))

endmodule

@@ verif/jti_checker.sv @@
// Checker for the jerk triple integrator: predicts command results and compares them.
module jti_checker
    import jti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NJ = 7;

    logic signed [31:0] pos_q [NJ];
    logic signed [31:0] vel_q [NJ];
    logic signed [31:0] acc_q [NJ];
    logic signed [31:0] jerk_q [NJ];
    logic        live;
    logic        first_load;
    logic [31:0] sol_stamp;
    logic [31:0] tick_stamp;
    logic [19:0] timeout_r, dt_max_r, dt_min_r, def_dt_r;
    out_item_t   cmd_queue[$];

    assign pending = cmd_queue.size();

    // Floor of x * c / 2^32, kept wide so no bits are lost.
    function automatic logic signed [63:0] scale_q32(input logic signed [31:0] x,
                                                    input logic [31:0] c);
        logic signed [65:0] p;
        p = $signed({{34{x[31]}}, x}) * $signed({34'd0, c});
        return 64'(p >>> 32);
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [63:0] v,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
        if (v < 64'(lo))
            return lo;
        if (v > 64'(hi))
            return hi;
        return v[31:0];
    endfunction

    // Advance every joint by one tick and queue the resulting commands.
    task automatic integrate_tick(input logic [31:0] now);
        logic [31:0] el, dt, d2, d3, hd2, sd3;
        logic [63:0] t;
        logic signed [63:0] np, nv, na;
        logic signed [31:0] lo, hi, vl, al;
        logic [4:0] r;
        out_item_t o;
        el = now - tick_stamp;
        if (el > 32'(dt_max_r))
            el = 32'(dt_max_r);
        if (el < 32'(dt_min_r))
            el = 32'(def_dt_r);
        tick_stamp = now;
        t = ({32'd0, el} << 32) / 64'd1000000;
        dt = (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
        d2 = 32'(({32'd0, dt} * {32'd0, dt}) >> 32);
        d3 = 32'(({32'd0, d2} * {32'd0, dt}) >> 32);
        hd2 = d2 >> 1;
        sd3 = d3 / 6;
        for (int i = 0; i < NJ; i++)
        begin
            r = 5'(i);
            np = 64'(pos_q[i]) + scale_q32(vel_q[i], dt) + scale_q32(acc_q[i], hd2)
                 + scale_q32(jerk_q[i], sd3);
            nv = 64'(vel_q[i]) + scale_q32(acc_q[i], dt) + scale_q32(jerk_q[i], hd2);
            na = 64'(acc_q[i]) + scale_q32(jerk_q[i], dt);
            lo = pos_lo(r);
            hi = pos_hi(r);
            vl = vel_lim(r);
            al = acc_lim(r);
            pos_q[i] = sat(np, lo, hi);
            vel_q[i] = sat(nv, -vl, vl);
            acc_q[i] = sat(na, -al, al);
            o.out_joint = 3'(i);
            o.cmd_position = pos_q[i];
            o.cmd_velocity = vel_q[i];
            o.cmd_acceleration = acc_q[i];
            o.last_of_run = (i == NJ - 1);
            cmd_queue = {cmd_queue, o};
        end
    endtask

    task automatic apply_item(input in_item_t it);
        if (it.opcode == OP_SOLUTION)
        begin
            if (it.joint_index < NJ)
            begin
                if (first_load)
                begin
                    pos_q[it.joint_index] = it.start_position;
                    vel_q[it.joint_index] = it.start_velocity;
                    acc_q[it.joint_index] = it.start_acceleration;
                end
                if (it.jerk_valid)
                    jerk_q[it.joint_index] = it.jerk_value;
            end
            sol_stamp = it.time_us;
            live = 1'b1;
            if (it.last_joint)
                first_load = 1'b0;
        end
        else if (live)
        begin
            if (it.time_us - sol_stamp > 32'(timeout_r))
                live = 1'b0;
            else
                integrate_tick(it.time_us);
        end
    endtask

    // Model state, configuration writes, input transactions and result checks.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NJ; i++)
            begin
                pos_q[i] = '0;
                vel_q[i] = '0;
                acc_q[i] = '0;
                jerk_q[i] = '0;
            end
            live = 1'b0;
            first_load = 1'b1;
            sol_stamp = '0;
            tick_stamp = '0;
            timeout_r = 20'd70000;
            dt_max_r = 20'd10000;
            dt_min_r = 20'd100;
            def_dt_r = 20'd1000;
            cmd_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_r = cfg_data;
                    CFG_DT_MAX: dt_max_r = cfg_data;
                    CFG_DT_MIN: dt_min_r = cfg_data;
                    CFG_DEFAULT_DT: def_dt_r = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                apply_item(in_data);
            if (out_valid && !out_stall)
            begin
                if (cmd_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected command result: %p", out_data);
                end
                else
                begin
                    want = cmd_queue.pop_front();
                    if (want !== out_data)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("command mismatch: expected %p, actual %p",
                                     want, out_data);
                    end
                end
            end
        end
    end
endmodule

@@ verif/tb_jerk_triple_integrator.sv @@
// Testbench top for the jerk triple integrator: stimulus, configuration and verdict.
module tb_jerk_triple_integrator;
    import jti_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;
    int          fail_count;
    int          pending;
    logic        no_idle;
    logic [31:0] clock_us;

    jerk_triple_integrator dut (.*);

    jti_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver stall, random except while no_idle is set.
    always @(posedge clk)
        out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 27);

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'($signed($urandom_range(8000000)) - 4000000);
            3: return 32'($signed($urandom_range(200000)) - 100000);
            default: return $urandom();
        endcase
    endfunction

    // Send one transaction, with random idle cycles before it. Valid stays
    // high after acceptance until the next transaction or an idle cycle.
    task automatic send_item(input in_item_t it);
        while (!no_idle && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_solution(input logic [2:0] j, input logic last, input logic [31:0] t);
        in_item_t it;
        it.opcode = OP_SOLUTION;
        it.joint_index = j;
        it.time_us = t;
        it.start_position = rand_q();
        it.start_velocity = rand_q();
        it.start_acceleration = rand_q();
        it.jerk_value = rand_q();
        it.jerk_valid = $urandom_range(3) != 0;
        it.last_joint = last;
        send_item(it);
    endtask

    task automatic send_tick(input logic [31:0] t);
        in_item_t it;
        logic [191:0] noise;
        noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        it = noise[$bits(in_item_t)-1:0];
        it.opcode = OP_TICK;
        it.time_us = t;
        send_item(it);
    endtask

    // Full solution for all joints, optionally with a stray out-of-range joint.
    task automatic send_full_solution();
        for (int j = 0; j < 7; j++)
            send_solution(3'(j), j == 6, clock_us);
        if ($urandom_range(7) == 0)
            send_solution(3'd7, 1'($urandom_range(1)), clock_us);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_timing(input logic [19:0] to, input logic [19:0] mx,
                              input logic [19:0] mn, input logic [19:0] df);
        drain();
        write_cfg(CFG_TIMEOUT, to);
        write_cfg(CFG_DT_MAX, mx);
        write_cfg(CFG_DT_MIN, mn);
        write_cfg(CFG_DEFAULT_DT, df);
        cfg_valid <= 1'b0;
    endtask

    // Random phase: a random mix of full solutions, single solutions and ticks with random time steps.
    task automatic random_phase(input int n);
        int k;
        k = 0;
        while (k < n)
        begin
            case ($urandom_range(9))
                0: begin send_full_solution(); k += 7; end
                1: begin send_solution(3'($urandom_range(7)), 1'($urandom_range(1)),
                                       clock_us);
                   k++; end
                2: begin clock_us += $urandom(); send_tick(clock_us); k++; end
                default:
                begin
                    clock_us += $urandom_range(2) == 0 ? $urandom_range(300)
                                                       : $urandom_range(12000);
                    send_tick(clock_us);
                    k++;
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TIMEOUT;
        cfg_data = '0;
        no_idle = 1'b0;
        clock_us = 32'd5000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick before any solution, first load, tick sequence.
        send_tick(clock_us);
        send_full_solution();
        send_tick(clock_us);
        clock_us += 50;
        send_tick(clock_us);
        clock_us += 20000;
        send_tick(clock_us);
        send_solution(3'd2, 1'b0, clock_us);
        clock_us += 1000;
        send_tick(clock_us);
        // Watchdog expiry, then a tick with no live solution.
        clock_us += 80000;
        send_tick(clock_us);
        send_tick(clock_us);
        // Extremes of the registers: step of a second and more, zero step.
        set_timing(20'd1000000, 20'd1000000, 20'd0, 20'd1);
        send_solution(3'd0, 1'b1, clock_us);
        clock_us += 1000000;
        send_tick(clock_us);
        set_timing(20'd0, 20'd1, 20'd1000000, 20'd1000000);
        send_solution(3'd4, 1'b0, clock_us);
        send_tick(clock_us);
        set_timing(20'd1000000, 20'd1, 20'd1000000, 20'd0);
        send_solution(3'd5, 1'b0, clock_us);
        send_tick(clock_us + 7);

        // Random phases under several settings.
        set_timing(20'd70000, 20'd10000, 20'd100, 20'd1000);
        random_phase(140);
        no_idle <= 1'b1;
        set_timing(20'd1000000, 20'd20000, 20'd0, 20'd500);
        random_phase(80);
        no_idle <= 1'b0;
        set_timing(20'($urandom_range(30000)), 20'($urandom_range(1, 5000)),
                   20'($urandom_range(2000)), 20'($urandom_range(1, 3000)));
        random_phase(100);
        set_timing(20'd70000, 20'd10000, 20'd100, 20'd1000);
        random_phase(80);
        drain();

        if (fail_count == 0)
            $display("tb_jerk_triple_integrator: PASS");
        else
            $display("tb_jerk_triple_integrator: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_jerk_triple_integrator: FAIL");
        $finish;
    end
endmodule
